[rtl/ptt_pkg.sv]
// Shared types and constants of the periodic timer table.
package ptt_pkg;

	localparam int TARGET_W   = 16;
	localparam int SELECTOR_W = 8;
	localparam int INTERVAL_W = 24;
	localparam int COUNT_W    = 24;
	localparam int PERIOD_W   = 10;
	localparam int PROD_W     = COUNT_W + PERIOD_W;
	localparam int REQ_W      = 2;
	localparam int KIND_W     = 3;

	localparam logic [COUNT_W-1:0]  COUNT_MAX      = {COUNT_W{1'b1}};
	localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = PERIOD_W'(10);

	localparam logic [REQ_W-1:0] REQ_SCHEDULE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UNSCHEDULE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK       = 2'd2;

	localparam logic [KIND_W-1:0] KIND_FIRE        = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SCHEDULED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DUPLICATE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL        = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UNSCHEDULED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE   = 3'd6;

	typedef struct packed {
		logic [TARGET_W-1:0]   target;
		logic [SELECTOR_W-1:0] selector;
		logic [INTERVAL_W-1:0] interval;
		logic [COUNT_W-1:0]    count;
	} entry_t;

endpackage

[rtl/periodic_timer_table_unit.sv]
// Top level of the periodic timer table: slot memory, walk sequencer and result register.
//
// Requests come in on the input channel (in_valid, in_stall) as one word with
// req_type, target_id, selector_id and interval_ms. Results leave on the output
// channel (out_valid, out_stall); the last word of each request has last set.
// The user must write the tick period through the configuration channel
// (cfg_valid, cfg_ready, cfg_data) only while the block is idle; the block
// itself does not enforce this, and cfg_ready is always high. Every schedule,
// unschedule or tick request walks all NUM_SLOTS entries of the slot memory,
// one read per cycle while the output is not stalled, through a read stage and
// a multiply stage, and the next request is taken once its final word has
// entered the output register. A tick issues its fire words as the walk
// reaches firing slots, then a done word. A schedule or unschedule issues one
// word at the end of its walk. An unused request type is taken and dropped without a walk.
// Reset clears the valid and paused bits of all slots and sets the tick period
// to 10; the slot memory itself is not cleared. While out_stall is high with a
// word waiting, the whole walk holds and resumes without loss.
module periodic_timer_table_unit #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ptt_pkg::REQ_W-1:0]           req_type,
	input  logic [ptt_pkg::TARGET_W-1:0]        target_id,
	input  logic [ptt_pkg::SELECTOR_W-1:0]      selector_id,
	input  logic [ptt_pkg::INTERVAL_W-1:0]      interval_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ptt_pkg::KIND_W-1:0]          result_kind,
	output logic [ptt_pkg::TARGET_W-1:0]        fired_target,
	output logic [ptt_pkg::SELECTOR_W-1:0]      fired_selector,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptt_pkg::PERIOD_W-1:0]        cfg_data
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                          state_q;
	logic [ptt_pkg::PERIOD_W-1:0]        period_q;
	logic [NUM_SLOTS-1:0]                valid_q;
	logic [NUM_SLOTS-1:0]                paused_q;
	logic [IDX_W-1:0]                    idx_q;
	logic [ptt_pkg::REQ_W-1:0]           req_q;
	logic [ptt_pkg::TARGET_W-1:0]        tgt_q;
	logic [ptt_pkg::SELECTOR_W-1:0]      sel_q;
	logic [ptt_pkg::INTERVAL_W-1:0]      ivl_q;
	logic                                found_q;
	logic [IDX_W-1:0]                    found_idx_q;
	logic                                free_found_q;
	logic [IDX_W-1:0]                    free_idx_q;

	ptt_pkg::entry_t                     mem [NUM_SLOTS];
	ptt_pkg::entry_t                     rd_data_s1;
	logic                                s1_v;
	logic [IDX_W-1:0]                    s1_idx;
	logic                                s2_v;
	logic [IDX_W-1:0]                    s2_idx;
	ptt_pkg::entry_t                     entry_s2;
	logic [ptt_pkg::PROD_W-1:0]          prod_s2;

	logic                                out_valid_q;
	logic [ptt_pkg::KIND_W-1:0]          kind_q;
	logic [ptt_pkg::TARGET_W-1:0]        otgt_q;
	logic [ptt_pkg::SELECTOR_W-1:0]      osel_q;
	logic                                last_q;

	logic                                adv;
	logic                                s2_act;
	logic                                s2_hit;
	logic                                s2_fire;
	logic                                tick_live;
	logic                                tick_free;
	logic                                fin;
	logic                                emit;
	logic [ptt_pkg::COUNT_W-1:0]         new_count;
	logic                                mem_we;
	logic [IDX_W-1:0]                    mem_waddr;
	ptt_pkg::entry_t                     mem_wdata;
	logic [ptt_pkg::KIND_W-1:0]          fin_kind;
	logic [ptt_pkg::KIND_W-1:0]          emit_kind;
	logic [ptt_pkg::TARGET_W-1:0]        emit_tgt;
	logic [ptt_pkg::SELECTOR_W-1:0]      emit_sel;

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign s2_act  = adv && s2_v;
	assign s2_hit  = valid_q[s2_idx] && (entry_s2.target == tgt_q) &&
		(entry_s2.selector == sel_q);
	assign s2_fire = (prod_s2 >= ptt_pkg::PROD_W'(entry_s2.interval));
	assign tick_live = s2_act && (req_q == ptt_pkg::REQ_TICK) &&
		valid_q[s2_idx] && !paused_q[s2_idx];
	assign tick_free = s2_act && (req_q == ptt_pkg::REQ_TICK) &&
		valid_q[s2_idx] && paused_q[s2_idx];
	assign fin  = adv && (state_q == ST_FINISH);
	assign emit = (tick_live && s2_fire) || fin;

	always_comb begin
		if (s2_fire) begin
			new_count = ptt_pkg::COUNT_W'(1);
		end else if (entry_s2.count == ptt_pkg::COUNT_MAX) begin
			new_count = entry_s2.count;
		end else begin
			new_count = entry_s2.count + ptt_pkg::COUNT_W'(1);
		end
	end

	always_comb begin
		case (req_q)
			ptt_pkg::REQ_SCHEDULE: begin
				if (found_q) begin
					fin_kind = ptt_pkg::KIND_DUPLICATE;
				end else if (!free_found_q) begin
					fin_kind = ptt_pkg::KIND_FULL;
				end else begin
					fin_kind = ptt_pkg::KIND_SCHEDULED;
				end
			end
			ptt_pkg::REQ_UNSCHEDULE: begin
				fin_kind = found_q ? ptt_pkg::KIND_UNSCHEDULED : ptt_pkg::KIND_NOT_FOUND;
			end
			default: begin
				fin_kind = ptt_pkg::KIND_TICK_DONE;
			end
		endcase
	end

	always_comb begin
		if (fin) begin
			emit_kind = fin_kind;
			emit_tgt  = (req_q == ptt_pkg::REQ_TICK) ? '0 : tgt_q;
			emit_sel  = (req_q == ptt_pkg::REQ_TICK) ? '0 : sel_q;
		end else begin
			emit_kind = ptt_pkg::KIND_FIRE;
			emit_tgt  = entry_s2.target;
			emit_sel  = entry_s2.selector;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = s2_idx;
		mem_wdata = entry_s2;
		if (tick_live) begin
			mem_we          = 1'b1;
			mem_wdata.count = new_count;
		end else if (fin && (req_q == ptt_pkg::REQ_SCHEDULE) && !found_q && free_found_q) begin
			mem_we             = 1'b1;
			mem_waddr          = free_idx_q;
			mem_wdata.target   = tgt_q;
			mem_wdata.selector = sel_q;
			mem_wdata.interval = ivl_q;
			mem_wdata.count    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_idx   <= idx_q;
			s2_idx   <= s1_idx;
			entry_s2 <= rd_data_s1;
			prod_s2  <= ptt_pkg::PROD_W'(rd_data_s1.count) * ptt_pkg::PROD_W'(period_q);
		end
		if (adv && emit) begin
			kind_q <= emit_kind;
			otgt_q <= emit_tgt;
			osel_q <= emit_sel;
			last_q <= fin;
		end
		if (state_q == ST_IDLE) begin
			req_q <= req_type;
			tgt_q <= target_id;
			sel_q <= selector_id;
			ivl_q <= interval_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			period_q     <= ptt_pkg::PERIOD_DEFAULT;
			valid_q      <= '0;
			paused_q     <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			s1_v         <= 1'b0;
			s2_v         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (adv) begin
				s1_v        <= (state_q == ST_WALK);
				s2_v        <= s1_v;
				out_valid_q <= emit;
			end

			if (s2_act && (req_q != ptt_pkg::REQ_TICK)) begin
				if (s2_hit && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= s2_idx;
				end
				if (!valid_q[s2_idx] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= s2_idx;
				end
			end
			if (tick_free) begin
				valid_q[s2_idx]  <= 1'b0;
				paused_q[s2_idx] <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q        <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					if (in_valid && (req_type == ptt_pkg::REQ_SCHEDULE ||
						req_type == ptt_pkg::REQ_UNSCHEDULE ||
						req_type == ptt_pkg::REQ_TICK)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (adv) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_LAST) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (adv && !s1_v) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (adv) begin
						state_q <= ST_IDLE;
						if (req_q == ptt_pkg::REQ_SCHEDULE && !found_q && free_found_q) begin
							valid_q[free_idx_q]  <= 1'b1;
							paused_q[free_idx_q] <= 1'b0;
						end
						if (req_q == ptt_pkg::REQ_UNSCHEDULE && found_q) begin
							paused_q[found_idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign fired_target   = otgt_q;
	assign fired_selector = osel_q;
	assign last           = last_q;

endmodule

[tb/sv/ptt_checker.sv]
// Checker that predicts the timer table's result words from accepted requests.
`timescale 1ns / 1ps

module ptt_checker #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic [ptt_pkg::REQ_W-1:0]               req_type,
	input  logic [ptt_pkg::TARGET_W-1:0]            target_id,
	input  logic [ptt_pkg::SELECTOR_W-1:0]          selector_id,
	input  logic [ptt_pkg::INTERVAL_W-1:0]          interval_ms,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic [ptt_pkg::KIND_W-1:0]              result_kind,
	input  logic [ptt_pkg::TARGET_W-1:0]            fired_target,
	input  logic [ptt_pkg::SELECTOR_W-1:0]          fired_selector,
	input  logic                                    last,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [ptt_pkg::PERIOD_W-1:0]            cfg_data,
	output int                                      mismatch_count,
	output int                                      pending_words,
	output int                                      checked_words,
	output int                                      fire_words
);

	typedef struct packed {
		logic [ptt_pkg::KIND_W-1:0]     kind;
		logic [ptt_pkg::TARGET_W-1:0]   target;
		logic [ptt_pkg::SELECTOR_W-1:0] selector;
		logic                           last;
	} result_word_t;

	result_word_t                 awaited_words[$];
	logic [ptt_pkg::PERIOD_W-1:0] tick_period;
	logic                         slot_live[NUM_SLOTS];
	logic                         slot_paused[NUM_SLOTS];
	ptt_pkg::entry_t              slot_entry[NUM_SLOTS];

	function automatic int find_timer(input logic [ptt_pkg::TARGET_W-1:0] tgt,
			input logic [ptt_pkg::SELECTOR_W-1:0] sel);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_live[i] && slot_entry[i].target == tgt &&
					slot_entry[i].selector == sel) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void await_word(input logic [ptt_pkg::KIND_W-1:0] kind,
			input logic [ptt_pkg::TARGET_W-1:0] tgt,
			input logic [ptt_pkg::SELECTOR_W-1:0] sel,
			input logic is_last);
		result_word_t word;
		word = {kind, tgt, sel, is_last};
		awaited_words = {awaited_words, word};
	endfunction

	function automatic void timer_table_step(input logic [ptt_pkg::REQ_W-1:0] req,
			input logic [ptt_pkg::TARGET_W-1:0] tgt,
			input logic [ptt_pkg::SELECTOR_W-1:0] sel,
			input logic [ptt_pkg::INTERVAL_W-1:0] ivl);
		int                         slot;
		logic [ptt_pkg::PROD_W-1:0] elapsed;
		if (req == ptt_pkg::REQ_SCHEDULE) begin
			if (find_timer(tgt, sel) >= 0) begin
				await_word(ptt_pkg::KIND_DUPLICATE, tgt, sel, 1'b1);
				return;
			end
			slot = -1;
			for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
				if (!slot_live[i]) begin
					slot = i;
				end
			end
			if (slot < 0) begin
				await_word(ptt_pkg::KIND_FULL, tgt, sel, 1'b1);
				return;
			end
			slot_live[slot] = 1'b1;
			slot_paused[slot] = 1'b0;
			slot_entry[slot].target = tgt;
			slot_entry[slot].selector = sel;
			slot_entry[slot].interval = ivl;
			slot_entry[slot].count = '0;
			await_word(ptt_pkg::KIND_SCHEDULED, tgt, sel, 1'b1);
		end else if (req == ptt_pkg::REQ_UNSCHEDULE) begin
			slot = find_timer(tgt, sel);
			if (slot < 0) begin
				await_word(ptt_pkg::KIND_NOT_FOUND, tgt, sel, 1'b1);
			end else begin
				slot_paused[slot] = 1'b1;
				await_word(ptt_pkg::KIND_UNSCHEDULED, tgt, sel, 1'b1);
			end
		end else if (req == ptt_pkg::REQ_TICK) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot_live[i] && slot_paused[i]) begin
					slot_live[i] = 1'b0;
					slot_paused[i] = 1'b0;
				end else if (slot_live[i]) begin
					elapsed = ptt_pkg::PROD_W'(slot_entry[i].count) *
						ptt_pkg::PROD_W'(tick_period);
					if (elapsed >= ptt_pkg::PROD_W'(slot_entry[i].interval)) begin
						slot_entry[i].count = '0;
						await_word(ptt_pkg::KIND_FIRE, slot_entry[i].target,
							slot_entry[i].selector, 1'b0);
					end
					if (slot_entry[i].count != ptt_pkg::COUNT_MAX) begin
						slot_entry[i].count = slot_entry[i].count +
							ptt_pkg::COUNT_W'(1);
					end
				end
			end
			await_word(ptt_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
		end
	endfunction

	function automatic void check_word();
		result_word_t want;
		result_word_t got;
		got = {result_kind, fired_target, fired_selector, last};
		checked_words++;
		if (result_kind == ptt_pkg::KIND_FIRE) begin
			fire_words++;
		end
		if (awaited_words.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: unexpected word kind %0d target %h selector %h last %b",
					$realtime, got.kind, got.target, got.selector, got.last);
			end
			return;
		end
		want = awaited_words.pop_front();
		if (got.kind !== want.kind || got.target !== want.target
				|| got.selector !== want.selector || got.last !== want.last) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: expected kind %0d target %h selector %h last %b,",
					$realtime, want.kind, want.target, want.selector, want.last);
				$display("    got kind %0d target %h selector %h last %b",
					got.kind, got.target, got.selector, got.last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period = ptt_pkg::PERIOD_DEFAULT;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_paused[i] = 1'b0;
				slot_entry[i] = '0;
			end
			awaited_words.delete();
			mismatch_count = 0;
			pending_words = 0;
			checked_words = 0;
			fire_words = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_word();
			end
			if (cfg_valid && cfg_ready) begin
				tick_period = cfg_data;
			end
			if (in_valid && !in_stall) begin
				timer_table_step(req_type, target_id, selector_id, interval_ms);
			end
			pending_words = awaited_words.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Top of the timer table testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb;

	localparam int                        NUM_SLOTS     = 16;
	localparam int                        SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
	localparam int                        HOLD_CYCLES   = 400;
	localparam logic [ptt_pkg::REQ_W-1:0] REQ_UNUSED    = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [ptt_pkg::REQ_W-1:0]      req_type;
	logic [ptt_pkg::TARGET_W-1:0]   target_id;
	logic [ptt_pkg::SELECTOR_W-1:0] selector_id;
	logic [ptt_pkg::INTERVAL_W-1:0] interval_ms;
	logic                           out_valid;
	logic                           out_stall;
	logic [ptt_pkg::KIND_W-1:0]     result_kind;
	logic [ptt_pkg::TARGET_W-1:0]   fired_target;
	logic [ptt_pkg::SELECTOR_W-1:0] fired_selector;
	logic                           last;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ptt_pkg::PERIOD_W-1:0]   cfg_data;

	int                             mismatch_count;
	int                             pending_words;
	int                             checked_words;
	int                             fire_words;
	int                             sender_idle_pct;
	int                             receiver_idle_pct;
	int                             requests_sent;
	logic                           long_hold_start;
	logic [ptt_pkg::PERIOD_W-1:0]   cur_period;

	periodic_timer_table_unit #(
		.NUM_SLOTS(NUM_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.target_id(target_id),
		.selector_id(selector_id),
		.interval_ms(interval_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.fired_target(fired_target),
		.fired_selector(fired_selector),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	ptt_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.target_id(target_id),
		.selector_id(selector_id),
		.interval_ms(interval_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.fired_target(fired_target),
		.fired_selector(fired_selector),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.pending_words(pending_words),
		.checked_words(checked_words),
		.fire_words(fire_words)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver stalls at random, or for one long stretch when asked.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (long_hold_start) begin
				long_hold_start = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	initial begin
		#(64'd4_000_000);
		$display("Timeout with %0d words still awaited.", pending_words);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_request(input logic [ptt_pkg::REQ_W-1:0] req,
			input logic [ptt_pkg::TARGET_W-1:0] tgt,
			input logic [ptt_pkg::SELECTOR_W-1:0] sel,
			input logic [ptt_pkg::INTERVAL_W-1:0] ivl);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = req;
		target_id = tgt;
		selector_id = sel;
		interval_ms = ivl;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		in_valid = 1'b0;
		requests_sent++;
	endtask

	task automatic send_random(inout int counted);
		int                             pick;
		int                             scale;
		logic [ptt_pkg::REQ_W-1:0]      req;
		logic [ptt_pkg::TARGET_W-1:0]   tgt;
		logic [ptt_pkg::SELECTOR_W-1:0] sel;
		logic [ptt_pkg::INTERVAL_W-1:0] ivl;
		pick = $urandom_range(0, 99);
		if (pick < 42) begin
			req = ptt_pkg::REQ_TICK;
		end else if (pick < 72) begin
			req = ptt_pkg::REQ_SCHEDULE;
		end else if (pick < 95) begin
			req = ptt_pkg::REQ_UNSCHEDULE;
		end else begin
			req = REQ_UNUSED;
		end
		// Most requests use a small pool of timers so that duplicates and hits are common.
		if ($urandom_range(0, 3) != 0) begin
			tgt = ptt_pkg::TARGET_W'($urandom_range(0, 7));
			sel = ptt_pkg::SELECTOR_W'($urandom_range(0, 3));
		end else begin
			tgt = ptt_pkg::TARGET_W'($urandom);
			sel = ptt_pkg::SELECTOR_W'($urandom);
		end
		scale = 6 * int'(cur_period) + 3;
		if ($urandom_range(0, 7) == 0) begin
			ivl = ptt_pkg::INTERVAL_W'($urandom);
		end else begin
			ivl = ptt_pkg::INTERVAL_W'($urandom_range(0, scale));
		end
		send_request(req, tgt, sel, ivl);
		if (req != REQ_UNUSED) begin
			counted++;
		end
	endtask

	task automatic settle();
		wait (pending_words == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_period(input logic [ptt_pkg::PERIOD_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_period = value;
	endtask

	task automatic run_phase(input logic [ptt_pkg::PERIOD_W-1:0] period, input int items,
			input int send_pct, input int recv_pct, input int drain_at, input int hold_at);
		int   counted;
		logic drained;
		logic held;
		counted = 0;
		drained = 1'b0;
		held = 1'b0;
		settle();
		write_period(period);
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		while (counted < items) begin
			if (counted == drain_at && !drained) begin
				drained = 1'b1;
				wait (pending_words == 0);
			end
			if (counted == hold_at && !held) begin
				held = 1'b1;
				long_hold_start = 1'b1;
			end
			send_random(counted);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		req_type = ptt_pkg::REQ_SCHEDULE;
		target_id = '0;
		selector_id = '0;
		interval_ms = '0;
		cfg_valid = 1'b0;
		cfg_data = ptt_pkg::PERIOD_DEFAULT;
		sender_idle_pct = 22;
		receiver_idle_pct = 71;
		long_hold_start = 1'b0;
		requests_sent = 0;
		cur_period = ptt_pkg::PERIOD_DEFAULT;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset tick period.
		send_request(ptt_pkg::REQ_TICK, '0, '0, '0);
		send_request(ptt_pkg::REQ_SCHEDULE, '1, '1, '0);
		send_request(ptt_pkg::REQ_SCHEDULE, '0, '0, '1);
		send_request(ptt_pkg::REQ_UNSCHEDULE, 16'h0001, 8'h02, '0);
		send_request(REQ_UNUSED, 16'h5A5A, 8'hA5, 24'h123456);
		send_request(ptt_pkg::REQ_TICK, '0, '0, '0);
		send_request(ptt_pkg::REQ_UNSCHEDULE, '1, '1, '0);
		send_request(ptt_pkg::REQ_UNSCHEDULE, '1, '1, '0);
		send_request(ptt_pkg::REQ_SCHEDULE, '1, '1, 24'd5);
		send_request(ptt_pkg::REQ_TICK, '0, '0, '0);
		for (int k = 1; k < NUM_SLOTS; k++) begin
			send_request(ptt_pkg::REQ_SCHEDULE, ptt_pkg::TARGET_W'(k % 8),
				ptt_pkg::SELECTOR_W'(k / 8), ptt_pkg::INTERVAL_W'(k * 10));
		end
		send_request(ptt_pkg::REQ_SCHEDULE, 16'h1234, 8'h56, 24'd7);

		run_phase(ptt_pkg::PERIOD_W'(1), 30, 22, 71, 15, -1);
		run_phase(ptt_pkg::PERIOD_W'(0), 20, 71, 22, -1, -1);
		run_phase(ptt_pkg::PERIOD_W'(1023), 20, 0, 0, -1, -1);
		run_phase(ptt_pkg::PERIOD_W'(1000), 15, 0, 0, -1, 3);
		settle();

		$display("Covered %0d requests over tick periods 10, 1, 0, 1023 and 1000,",
			requests_sent);
		$display("with %0d result words checked, %0d of them fires.", checked_words,
			fire_words);
		if (mismatch_count == 0 && pending_words == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[files.f]
rtl/ptt_pkg.sv
rtl/periodic_timer_table_unit.sv
tb/sv/ptt_checker.sv
tb/sv/tb.sv
